// File: hw/rtl/reference_count_table_unit_macros.svh
// assertion macros for the reference count table
`ifndef REFERENCE_COUNT_TABLE_UNIT_MACROS_SVH
`define REFERENCE_COUNT_TABLE_UNIT_MACROS_SVH

`ifndef SYNTH
`define RCT_ASSERT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("rct assertion failed");
`define RCT_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rct assertion failed");
`else
`define RCT_ASSERT(lbl, pre, post)
`define RCT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: hw/rtl/rct_pkg.sv
// shared constants and types for the reference count table
`default_nettype none

package rct_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int COUNT_CEILING = 128;
    localparam int MAX_RESULTS   = 32;
    localparam int NUM_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_USE     = 2'd0;
    localparam logic [1:0] OP_DISUSE  = 2'd1;
    localparam logic [1:0] OP_COLLECT = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;

    typedef struct packed {
        logic        lookup;
        logic        is_use;
        logic        any_match;
        logic        shift;
        logic        release_tok;
        logic        clear;
        logic [31:0] address;
    } t_cell_cmd;

    typedef struct packed {
        logic        token;
        logic        match;
        logic        tok_hit;
        logic [7:0]  count;
        logic [31:0] address;
    } t_cell_stat;

endpackage

`default_nettype wire

// File: hw/rtl/rct_cell.sv
// one table slot: address, count, valid bit and collect token
`default_nettype none

module rct_cell
    import rct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_cmd  i_cmd,
    input  wire logic       i_free_below,
    output logic            o_free_below,
    input  wire logic       i_token,
    output t_cell_stat      o_stat
);

    logic        r_valid;
    logic        r_token;
    logic [31:0] r_address;
    logic [7:0]  r_count;

    logic w_match;
    logic w_claim;
    logic w_zero;

    assign w_match      = r_valid && (r_address == i_cmd.address);
    assign w_claim      = !r_valid && !i_free_below;
    assign o_free_below = i_free_below || !r_valid;
    assign w_zero       = (r_count == 8'd0);

    assign o_stat.token   = r_token;
    assign o_stat.match   = w_match;
    assign o_stat.tok_hit = r_token && r_valid && w_zero;
    assign o_stat.count   = w_match ? r_count : 8'd0;
    assign o_stat.address = r_token ? r_address : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_token <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_token <= 1'b0;
            end else if (i_cmd.shift) begin
                r_token <= i_token;
            end
            if (i_cmd.release_tok && r_token) begin
                r_valid <= 1'b0;
            end
            if (i_cmd.lookup) begin
                if (w_match && i_cmd.is_use && (r_count < 8'(COUNT_CEILING))) begin
                    r_count <= r_count + 8'd1;
                end else if (w_match && !i_cmd.is_use && !w_zero) begin
                    r_count <= r_count - 8'd1;
                end else if (w_claim && i_cmd.is_use && !i_cmd.any_match) begin
                    r_valid   <= 1'b1;
                    r_address <= i_cmd.address;
                    r_count   <= 8'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/reference_count_table_unit.sv
// reference count table: a row of slot cells with a lookup and collect controller
//
// input stream carries one request: tuser holds the op (use, disuse, collect),
// tdata the 32-bit address. output stream gives the results from a single
// output register; tdata holds status, freed address and count, tuser the
// freed flag, tlast marks the final result of a request.
// use and disuse: the request is registered, looked up in S_LOOKUP and its
// result written to the output register; all cells compare the address at once,
// the lowest free cell is claimed through the free chain from cell to cell.
// collect: a token walks the cells one per cycle while the output does not stall;
// each released address is held in a pending register so the final one can carry
// tlast.
// reset clears all valid bits, tokens and the garbage mark; slots need no pass.
// a stalled receiver holds the output register, and the walk or lookup waits
// until the register can take the next result. requests are taken only while
// the controller is idle.
`default_nettype none
`include "reference_count_table_unit_macros.svh"

module reference_count_table_unit
    import rct_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // address
    input  wire logic [1:0]  s_axis_tuser,   // op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // status, freed_address, count_after, zero pad
    output logic             m_axis_tuser,   // freed_valid
    output logic             m_axis_tlast    // last
);

    typedef enum logic [1:0] {S_IDLE, S_LOOKUP, S_SWEEP, S_FINISH} t_state;

    t_state      r_state;
    logic [1:0]  r_op;
    logic [31:0] r_addr;
    logic        r_garbage;
    logic        r_pend;
    logic [31:0] r_pend_addr;
    logic [NUM_W-1:0] r_num;

    logic        r_out_valid;
    logic [2:0]  r_out_status;
    logic        r_out_fv;
    logic [31:0] r_out_addr;
    logic        r_out_last;
    logic [7:0]  r_out_count;

    t_cell_cmd   w_cmd;
    t_cell_stat  w_stat [TABLE_ENTRIES];
    logic        w_free [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_token_vec;
    logic [TABLE_ENTRIES-1:0] w_match_vec;

    logic        w_accept;
    logic        w_start;
    logic        w_out_free;
    logic        w_found;
    logic [7:0]  w_found_count;
    logic        w_tok_hit;
    logic [31:0] w_tok_addr;
    logic        w_tok_last;
    logic        w_any_free;
    logic        w_limit;
    logic        w_take;
    logic        w_adv;
    logic        w_load;
    logic [2:0]  w_lk_status;
    logic [7:0]  w_lk_count;
    logic        w_lk_garbage;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && (s_axis_tuser == OP_COLLECT);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_free[0]     = 1'b0;
    assign w_any_free    = w_free[TABLE_ENTRIES];
    assign w_tok_last    = w_stat[TABLE_ENTRIES-1].token;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic w_tok_in;
        if (g == 0) begin : g_head
            assign w_tok_in = w_start;
        end else begin : g_body
            assign w_tok_in = w_stat[g-1].token;
        end
        rct_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_free_below (w_free[g]),
            .o_free_below (w_free[g+1]),
            .i_token      (w_tok_in),
            .o_stat       (w_stat[g])
        );
        assign w_token_vec[g] = w_stat[g].token;
        assign w_match_vec[g] = w_stat[g].match;
    end

    always_comb begin
        w_found       = 1'b0;
        w_found_count = 8'd0;
        w_tok_hit     = 1'b0;
        w_tok_addr    = 32'd0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            w_found       = w_found | w_stat[k].match;
            w_found_count = w_found_count | w_stat[k].count;
            w_tok_hit     = w_tok_hit | w_stat[k].tok_hit;
            w_tok_addr    = w_tok_addr | w_stat[k].address;
        end
    end

    // lookup result
    always_comb begin
        w_lk_status  = ST_OK;
        w_lk_count   = 8'd0;
        w_lk_garbage = 1'b0;
        if (r_addr != 32'd0) begin
            unique case (r_op)
                OP_USE: begin
                    if (w_found) begin
                        if (w_found_count < 8'(COUNT_CEILING)) begin
                            w_lk_count = w_found_count + 8'd1;
                        end else begin
                            w_lk_status = ST_OVERFLOW;
                            w_lk_count  = w_found_count;
                        end
                    end else if (w_any_free) begin
                        w_lk_count = 8'd1;
                    end else begin
                        w_lk_status = ST_FULL;
                    end
                end
                OP_DISUSE: begin
                    if (!w_found) begin
                        w_lk_status = ST_UNKNOWN;
                    end else if (w_found_count == 8'd0) begin
                        w_lk_status = ST_UNDERFLOW;
                    end else begin
                        w_lk_count   = w_found_count - 8'd1;
                        w_lk_garbage = (w_found_count == 8'd1);
                    end
                end
                default: begin
                    w_lk_status = ST_OK;
                end
            endcase
        end
    end

    // cell commands
    always_comb begin
        w_limit           = w_tok_hit && (r_num == NUM_W'(MAX_RESULTS));
        w_take            = w_tok_hit && !w_limit && (!r_pend || w_out_free);
        w_adv             = (r_state == S_SWEEP) && (w_take || !w_tok_hit);
        w_cmd             = '0;
        w_cmd.address     = r_addr;
        w_cmd.is_use      = (r_op == OP_USE);
        w_cmd.any_match   = w_found;
        w_cmd.lookup      = (r_state == S_LOOKUP) && w_out_free && (r_addr != 32'd0)
                            && ((r_op == OP_USE) || (r_op == OP_DISUSE));
        w_cmd.shift       = w_start || w_adv;
        w_cmd.release_tok = (r_state == S_SWEEP) && w_take;
        w_cmd.clear       = (r_state == S_SWEEP) && w_limit && w_out_free;
    end

    // output register takes a new result
    assign w_load = w_out_free && ((r_state == S_LOOKUP) || (r_state == S_FINISH)
                    || ((r_state == S_SWEEP) && (w_limit || (w_take && r_pend))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_garbage   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_num       <= '0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= s_axis_tuser;
                        r_addr <= s_axis_tdata;
                        r_pend <= 1'b0;
                        r_num  <= '0;
                        r_state <= w_start ? S_SWEEP : S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    if (w_out_free) begin
                        r_out_status <= w_lk_status;
                        r_out_fv     <= 1'b0;
                        r_out_addr   <= 32'd0;
                        r_out_last   <= 1'b1;
                        r_out_count  <= w_lk_count;
                        if (w_lk_garbage) begin
                            r_garbage <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    if (w_limit) begin
                        if (w_out_free) begin
                            r_out_status <= ST_OK;
                            r_out_fv     <= 1'b1;
                            r_out_addr   <= r_pend_addr;
                            r_out_last   <= 1'b1;
                            r_out_count  <= 8'd0;
                            r_garbage    <= 1'b1;
                            r_pend       <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        if (w_take) begin
                            if (r_pend) begin
                                r_out_status <= ST_OK;
                                r_out_fv     <= 1'b1;
                                r_out_addr   <= r_pend_addr;
                                r_out_last   <= 1'b0;
                                r_out_count  <= 8'd0;
                            end
                            r_pend_addr <= w_tok_addr;
                            r_pend      <= 1'b1;
                            r_num       <= r_num + NUM_W'(1);
                        end
                        if (w_adv && w_tok_last) begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_status <= ST_OK;
                        r_out_fv     <= r_pend;
                        r_out_addr   <= r_pend ? r_pend_addr : 32'd0;
                        r_out_last   <= 1'b1;
                        r_out_count  <= 8'd0;
                        r_garbage    <= 1'b0;
                        r_pend       <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_addr, r_out_status};
    assign m_axis_tuser  = r_out_fv;
    assign m_axis_tlast  = r_out_last;

    `RCT_ASSERT(a_token_single, 1'b1, $onehot0(w_token_vec))
    `RCT_ASSERT(a_match_single, 1'b1, $onehot0(w_match_vec))
    `RCT_ASSERT(a_idle_no_token, r_state == S_IDLE, w_token_vec == '0)
    `RCT_ASSERT(a_num_bound, 1'b1, r_num <= NUM_W'(MAX_RESULTS))
    `RCT_ASSERT_NEXT(a_finish_clears_mark, (r_state == S_FINISH) && w_out_free, !r_garbage)

endmodule

`default_nettype wire
